// ----- rtl/bef_pkg.sv -----
// ----------------------------------------------------------------------------
// bef_pkg
// shared widths, constants and state types for the block edge fade unit
// ----------------------------------------------------------------------------
package bef_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COUNT_W   = 24;
    localparam int FADE_W    = 12;
    localparam int FRAC_W    = SAMPLE_W - 3;
    localparam int PCM_W     = 16;
    localparam int Q_W       = 15;
    localparam int MAG_W     = SAMPLE_W;
    localparam int TOP_W     = MAG_W + FADE_W;
    localparam int BOT_W     = FADE_W + FRAC_W;
    localparam int P_W       = BOT_W + Q_W;
    localparam int DIV_CNT_W = $clog2(Q_W);

    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(240);
    localparam logic [Q_W-1:0]    PCM_FULL   = {Q_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_GAIN,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_OUT
    } fade_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_STEP,
        DV_ROUND
    } div_state_t;

endpackage

// ----- rtl/bef_div.sv -----
// ----------------------------------------------------------------------------
// bef_div
// iterative restoring divider, one quotient bit per cycle, round half to even
// ----------------------------------------------------------------------------
module bef_div
    import bef_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [P_W-1:0]   dividend,
    input  logic [BOT_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   done_reg;
    logic [P_W-1:0]         rem_reg;
    logic [P_W-1:0]         dsh_reg;
    logic [BOT_W-1:0]       bot_reg;
    logic [Q_W-1:0]         q_reg;

    logic                   ge;
    logic [P_W-1:0]         diff;
    logic [BOT_W:0]         rem2;
    logic [BOT_W:0]         bot_ext;
    logic                   round_up;

    assign ge       = rem_reg >= dsh_reg;
    assign diff     = rem_reg - dsh_reg;
    assign rem2     = {rem_reg[BOT_W-1:0], 1'b0};
    assign bot_ext  = {1'b0, bot_reg};
    assign round_up = (rem2 > bot_ext) || ((rem2 == bot_ext) && q_reg[0]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_STEP;
                    cnt_next   = DIV_CNT_W'(Q_W - 1);
                end
            end
            DV_STEP:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = DV_ROUND;
                end
            end
            DV_ROUND:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == DV_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    rem_reg <= dividend;
                    dsh_reg <= P_W'({divisor, {(Q_W-1){1'b0}}});
                    bot_reg <= divisor;
                    q_reg   <= '0;
                end
            end
            DV_STEP:
            begin
                if (ge)
                begin
                    rem_reg <= diff;
                end
                q_reg   <= {q_reg[Q_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            DV_ROUND:
            begin
                q_reg <= q_reg + Q_W'(round_up);
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/block_edge_fade_pcm16_unit.sv -----
// ----------------------------------------------------------------------------
// block_edge_fade_pcm16_unit
// linear block-edge fade of a q2.21 sample, clip and round to stereo pcm16
// ----------------------------------------------------------------------------
// items are processed one at a time: a new input is taken only in the idle state,
// after the previous result has been loaded into the output register; a clipped
// sample skips the 15-step divider and goes straight to the output
// the next input is taken while the result still waits in the output register
// reset: asynchronous active low; position returns to 0, fade_len to 240
// ----------------------------------------------------------------------------
module block_edge_fade_pcm16_unit
    import bef_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [FADE_W-1:0]       cfg_wr_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [47:0]             s_axis_tdata,   // sample_in, block_frames
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,   // pcm_left, pcm_right
    output logic                    m_axis_tlast
);

    fade_state_t            state_reg, state_next;
    logic [FADE_W-1:0]      fade_reg;
    logic [COUNT_W-1:0]     pos_reg;
    logic                   m_valid_reg, m_valid_next;

    logic [SAMPLE_W-1:0]    sample_reg;
    logic [COUNT_W-1:0]     n_reg;
    logic [COUNT_W-1:0]     nm1_reg;
    logic [COUNT_W-1:0]     i_reg;
    logic                   last_reg;
    logic                   neg_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [FADE_W-1:0]      num_reg;
    logic [FADE_W-1:0]      den_reg;
    logic [TOP_W-1:0]       top_reg;
    logic [BOT_W-1:0]       bot_reg;
    logic [Q_W-1:0]         res_reg;
    logic [PCM_W-1:0]       pcm_reg;
    logic                   tlast_reg;

    logic                   in_xfer;
    logic                   div_start;
    logic                   out_load;
    logic                   full;
    logic                   div_done;
    logic [Q_W-1:0]         div_q;
    logic [P_W-1:0]         prod;
    logic [SAMPLE_W-1:0]    s_sample;
    logic [COUNT_W-1:0]     s_frames;
    logic [COUNT_W-1:0]     nm1;
    logic                   fade_on;
    logic [COUNT_W-1:0]     nmf;
    logic [PCM_W-1:0]       res_ext;

    assign s_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign s_frames = s_axis_tdata[SAMPLE_W+COUNT_W-1:SAMPLE_W];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign nm1      = n_reg - 1'b1;
    assign fade_on  = (fade_reg != '0) && (COUNT_W'({fade_reg, 1'b0}) < n_reg);
    assign nmf      = n_reg - COUNT_W'(fade_reg);
    assign full     = top_reg >= TOP_W'(bot_reg);
    assign prod     = {top_reg[BOT_W-1:0], {Q_W{1'b0}}} - P_W'(top_reg[BOT_W-1:0]);
    assign res_ext  = PCM_W'(res_reg);

    bef_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (bot_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_MUL;
            ST_MUL:  state_next = ST_CHK;
            ST_CHK:  state_next = full ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_CHK:  div_start     = !full;
            ST_OUT:  out_load      = !m_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fade_reg    <= FADE_RESET;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                fade_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                pos_reg <= last_reg ? '0 : i_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= s_sample;
            n_reg      <= (s_frames == '0) ? COUNT_W'(1) : s_frames;
        end
        if (state_reg == ST_POS)
        begin
            nm1_reg  <= nm1;
            i_reg    <= (pos_reg > nm1) ? nm1 : pos_reg;
            last_reg <= pos_reg >= nm1;
        end
        if (state_reg == ST_GAIN)
        begin
            neg_reg <= sample_reg[SAMPLE_W-1];
            mag_reg <= sample_reg[SAMPLE_W-1] ? MAG_W'(-sample_reg) : MAG_W'(sample_reg);
            if (fade_on && (i_reg < COUNT_W'(fade_reg)))
            begin
                num_reg <= i_reg[FADE_W-1:0];
                den_reg <= fade_reg;
            end
            else if (fade_on && (i_reg >= nmf))
            begin
                num_reg <= FADE_W'(nm1_reg - i_reg);
                den_reg <= fade_reg;
            end
            else
            begin
                num_reg <= FADE_W'(1);
                den_reg <= FADE_W'(1);
            end
        end
        if (state_reg == ST_MUL)
        begin
            top_reg <= TOP_W'(mag_reg) * TOP_W'(num_reg);
            bot_reg <= {den_reg, {FRAC_W{1'b0}}};
        end
        if ((state_reg == ST_CHK) && full)
        begin
            res_reg <= PCM_FULL;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg <= div_q;
        end
        if (out_load)
        begin
            pcm_reg   <= neg_reg ? PCM_W'(-res_ext) : res_ext;
            tlast_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {pcm_reg, pcm_reg};
    assign m_axis_tlast  = tlast_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_no_div_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !full)
        else $error("divider started on a clipped sample");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> pos_reg == '0)
        else $error("position not cleared after end of block");

    a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[PCM_W-1:0] != {1'b1, {(PCM_W-1){1'b0}}})
        else $error("pcm output out of range");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready && (state_reg == ST_POS))
        else $error("input taken while an item is in progress");
`endif

endmodule
